[rtl/srq_pkg.sv]
// srq_pkg: types, codes and sizes shared by the sorted request queue
// no dependencies; used by srq_cell, srq_chain and sorted_request_queue_core
`default_nettype none

package srq_pkg;

    // queue size and derived widths
    localparam int QUEUE_DEPTH = 16;
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int START_W     = 48;
    localparam int COUNT_W     = 16;
    localparam int TAG_W       = 8;
    localparam int KEY_W       = START_W + 1;
    localparam int FILL_W      = 5;

    // opcodes
    localparam logic OP_INSERT   = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    // status codes
    localparam logic [1:0] ST_INSERTED   = 2'd0;
    localparam logic [1:0] ST_DISPATCHED = 2'd1;
    localparam logic [1:0] ST_EMPTY      = 2'd2;
    localparam logic [1:0] ST_FULL       = 2'd3;

    // input item
    typedef struct packed {
        logic               opcode;
        logic [TAG_W-1:0]   req_tag;
        logic [START_W-1:0] start_sector;
        logic [COUNT_W-1:0] sector_count;
        logic               is_write;
    } req_item_t;

    // result item
    typedef struct packed {
        logic [1:0]         status;
        logic [TAG_W-1:0]   out_tag;
        logic [START_W-1:0] out_start;
        logic [COUNT_W-1:0] out_count;
        logic               out_write;
        logic [FILL_W-1:0]  fill_level;
    } rsp_item_t;

    // one held request with its precomputed end sector
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [TAG_W-1:0]   tag;
        logic [START_W-1:0] start;
        logic [COUNT_W-1:0] count;
        logic               wr;
    } srq_entry_t;

    // chain command
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_POP
    } srq_cmd_t;

    // broadcast control to every cell
    typedef struct packed {
        srq_cmd_t   cmd;
        srq_entry_t new_entry;
    } srq_ctl_t;

endpackage

`default_nettype wire

[rtl/srq_cell.sv]
// srq_cell: one slot of the sorted chain, compares and shifts with its neighbors
// depends on srq_pkg
`default_nettype none

module srq_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire srq_pkg::srq_ctl_t  ctl,
    input  wire logic               prev_le,
    input  wire srq_pkg::srq_entry_t prev_entry,
    input  wire logic               prev_valid,
    input  wire srq_pkg::srq_entry_t next_entry,
    input  wire logic               next_valid,
    output srq_pkg::srq_entry_t     entry,
    output logic                    valid,
    output logic                    le
);

    srq_pkg::srq_entry_t entry_reg;
    srq_pkg::srq_entry_t entry_next;
    logic                valid_reg;
    logic                valid_next;

    // held entry sorts at or before the new key
    assign le = valid_reg && (entry_reg.key <= ctl.new_entry.key);

    // next slot contents
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        case (ctl.cmd)
            srq_pkg::CMD_INSERT:
            begin
                if (!le)
                begin
                    if (prev_le)
                    begin
                        entry_next = ctl.new_entry;
                        valid_next = 1'b1;
                    end
                    else
                    begin
                        entry_next = prev_entry;
                        valid_next = prev_valid;
                    end
                end
            end
            srq_pkg::CMD_POP:
            begin
                entry_next = next_entry;
                valid_next = next_valid;
            end
            default:
            begin
                entry_next = entry_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    // slot valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // slot payload
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

[rtl/srq_chain.sv]
// srq_chain: row of srq_cell slots kept in ascending end-sector order
// depends on srq_pkg and srq_cell
`default_nettype none

module srq_chain (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire srq_pkg::srq_ctl_t   ctl,
    output srq_pkg::srq_entry_t      head
);

    srq_pkg::srq_entry_t              ent [srq_pkg::QUEUE_DEPTH];
    logic [srq_pkg::QUEUE_DEPTH-1:0]  vld;
    logic [srq_pkg::QUEUE_DEPTH-1:0]  lev;

    // cell row, neighbors wired left and right
    for (genvar i = 0; i < srq_pkg::QUEUE_DEPTH; i++)
    begin : g_cell
        logic                p_le;
        srq_pkg::srq_entry_t p_ent;
        logic                p_vld;
        srq_pkg::srq_entry_t n_ent;
        logic                n_vld;

        if (i == 0)
        begin : g_first
            assign p_le  = 1'b1;
            assign p_ent = ctl.new_entry;
            assign p_vld = 1'b0;
        end
        else
        begin : g_mid
            assign p_le  = lev[i-1];
            assign p_ent = ent[i-1];
            assign p_vld = vld[i-1];
        end

        if (i == srq_pkg::QUEUE_DEPTH - 1)
        begin : g_last
            assign n_ent = ctl.new_entry;
            assign n_vld = 1'b0;
        end
        else
        begin : g_inner
            assign n_ent = ent[i+1];
            assign n_vld = vld[i+1];
        end

        srq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .prev_le    (p_le),
            .prev_entry (p_ent),
            .prev_valid (p_vld),
            .next_entry (n_ent),
            .next_valid (n_vld),
            .entry      (ent[i]),
            .valid      (vld[i]),
            .le         (lev[i])
        );
    end

    assign head = ent[0];

endmodule

`default_nettype wire

[rtl/sorted_request_queue_core.sv]
// sorted_request_queue_core: disk request queue sorted by end sector
// depends on srq_pkg and srq_chain
//
//   channel | valid     | stall     | payload
//   request | req_valid | req_stall | req (srq_pkg::req_item_t)
//   result  | rsp_valid | rsp_stall | rsp (srq_pkg::rsp_item_t)
//
// an item first has its end sector added into the stage register, then the
// broadcast compare in every cell places or pops it and the result
// is registered; one item per cycle is sustained while results are taken
// reset clears the occupancy count, the slot valid flags and both valid stages
// a stalled result holds the stage, which then stalls the request side
`default_nettype none

module sorted_request_queue_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire srq_pkg::req_item_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output srq_pkg::rsp_item_t      rsp
);

    logic                          stg_valid_reg;
    logic                          stg_op_reg;
    srq_pkg::srq_entry_t           stg_entry_reg;
    logic [srq_pkg::OCC_W-1:0]     occ_reg;
    logic [srq_pkg::OCC_W-1:0]     occ_next;
    logic                          rsp_valid_reg;
    srq_pkg::rsp_item_t            rsp_reg;
    srq_pkg::rsp_item_t            rsp_next;
    srq_pkg::srq_ctl_t             ctl;
    srq_pkg::srq_entry_t           head;
    srq_pkg::srq_entry_t           new_entry;
    logic                          out_free;
    logic                          advance;
    logic                          accept;

    // handshake
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign advance   = stg_valid_reg && out_free;
    assign req_stall = stg_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;

    // end sector key of the incoming request
    always_comb
    begin
        new_entry.key   = {1'b0, req.start_sector}
                        + {{(srq_pkg::KEY_W - srq_pkg::COUNT_W){1'b0}}, req.sector_count};
        new_entry.tag   = req.req_tag;
        new_entry.start = req.start_sector;
        new_entry.count = req.sector_count;
        new_entry.wr    = req.is_write;
    end

    // command decode and result build
    always_comb
    begin
        ctl.cmd       = srq_pkg::CMD_HOLD;
        ctl.new_entry = stg_entry_reg;
        occ_next      = occ_reg;
        rsp_next      = '0;
        if (stg_op_reg == srq_pkg::OP_INSERT)
        begin
            if (occ_reg == srq_pkg::OCC_W'(srq_pkg::QUEUE_DEPTH))
            begin
                rsp_next.status = srq_pkg::ST_FULL;
            end
            else
            begin
                ctl.cmd         = srq_pkg::CMD_INSERT;
                occ_next        = occ_reg + 1'b1;
                rsp_next.status = srq_pkg::ST_INSERTED;
            end
        end
        else
        begin
            if (occ_reg == '0)
            begin
                rsp_next.status = srq_pkg::ST_EMPTY;
            end
            else
            begin
                ctl.cmd            = srq_pkg::CMD_POP;
                occ_next           = occ_reg - 1'b1;
                rsp_next.status    = srq_pkg::ST_DISPATCHED;
                rsp_next.out_tag   = head.tag;
                rsp_next.out_start = head.start;
                rsp_next.out_count = head.count;
                rsp_next.out_write = head.wr;
            end
        end
        rsp_next.fill_level = srq_pkg::FILL_W'(occ_next);
        if (!advance)
        begin
            ctl.cmd = srq_pkg::CMD_HOLD;
        end
    end

    // sorted slot row
    srq_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .head  (head)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            occ_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                stg_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stg_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
                occ_reg       <= occ_next;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_op_reg    <= req.opcode;
            stg_entry_reg <= new_entry;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

[verif/sorted_request_queue_core_test.sv]
// sorted_request_queue_core_test: self-checking bench for the sorted request queue
// depends on srq_pkg and sorted_request_queue_core; keeps its own sorted copy of the
// queue, predicts every result and compares each one field by field
`default_nettype none

module sorted_request_queue_core_test;
    import srq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [START_W-1:0] START_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // one request held in the bench copy of the queue
    typedef struct {
        logic [KEY_W-1:0]   end_sector;
        logic [TAG_W-1:0]   tag;
        logic [START_W-1:0] start;
        logic [COUNT_W-1:0] count;
        logic               wr;
    } held_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_item_t   req = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_item_t   rsp;

    held_req_t   sorted_reqs[$];
    rsp_item_t   owed_results[$];
    int          error_count = 0;
    int unsigned cycle_count = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;

    sorted_request_queue_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // apply one item to the bench queue and return the result it gives
    function automatic rsp_item_t apply_to_queue(input req_item_t item);
        rsp_item_t r;
        held_req_t h;
        int pos;
        r = '0;
        if (item.opcode == OP_INSERT)
        begin
            if (sorted_reqs.size() >= QUEUE_DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                h.end_sector = {1'b0, item.start_sector} + KEY_W'(item.sector_count);
                h.tag = item.req_tag;
                h.start = item.start_sector;
                h.count = item.sector_count;
                h.wr = item.is_write;
                // behind every entry with an end sector at or below the new one
                pos = 0;
                while (pos < sorted_reqs.size() && sorted_reqs[pos].end_sector <= h.end_sector)
                    pos++;
                sorted_reqs.insert(pos, h);
                r.status = ST_INSERTED;
            end
        end
        else if (sorted_reqs.size() == 0)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            h = sorted_reqs.pop_front();
            r.status = ST_DISPATCHED;
            r.out_tag = h.tag;
            r.out_start = h.start;
            r.out_count = h.count;
            r.out_write = h.wr;
        end
        r.fill_level = FILL_W'(sorted_reqs.size());
        return r;
    endfunction

    function automatic req_item_t make_req(input logic op, input logic [TAG_W-1:0] tag,
                                           input logic [START_W-1:0] start,
                                           input logic [COUNT_W-1:0] count, input logic wr);
        return {op, tag, start, count, wr};
    endfunction

    // random item; key ranges mix tight clusters (equal end sectors) with the full span
    function automatic req_item_t random_request(input int insert_pct);
        req_item_t item;
        item.opcode = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_DISPATCH;
        item.req_tag = TAG_W'($urandom);
        item.is_write = 1'($urandom);
        case ($urandom_range(3))
            0:
            begin
                item.start_sector = START_W'($urandom_range(63));
                item.sector_count = COUNT_W'($urandom_range(15));
            end
            1:
            begin
                item.start_sector = START_W'({$urandom, $urandom});
                item.sector_count = COUNT_W'($urandom);
            end
            2:
            begin
                item.start_sector = START_MAX - START_W'($urandom_range(255));
                item.sector_count = COUNT_W'($urandom);
            end
            default:
            begin
                item.start_sector = START_W'($urandom_range(4095));
                item.sector_count = COUNT_W'($urandom);
            end
        endcase
        return item;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // drive one item, hold it until taken, then record its expected result
    task automatic send_item(input req_item_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do
            @(posedge clk);
        while (!req_valid || req_stall);
        owed_results.push_back(apply_to_queue(item));
    endtask

    // sender pauses until every owed result is back
    task automatic wait_for_results;
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (owed_results.size() != 0);
    endtask

    // receiver stall
    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < stall_pct);

    // result check
    always @(posedge clk)
    begin : result_check
        rsp_item_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (owed_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h", rsp));
            end
            else
            begin
                want = owed_results.pop_front();
                compare_field("status", 64'(rsp.status), 64'(want.status));
                compare_field("out_tag", 64'(rsp.out_tag), 64'(want.out_tag));
                compare_field("out_start", 64'(rsp.out_start), 64'(want.out_start));
                compare_field("out_count", 64'(rsp.out_count), 64'(want.out_count));
                compare_field("out_write", 64'(rsp.out_write), 64'(want.out_write));
                compare_field("fill_level", 64'(rsp.fill_level), 64'(want.fill_level));
            end
        end
    end

    // dispatch on an empty queue, insert fields set but ignored
    task automatic test_empty_dispatch;
        send_item(make_req(OP_DISPATCH, 8'hA5, START_MAX, COUNT_MAX, 1'b1));
    endtask

    // same end sector from different start and count must leave in arrival order
    task automatic test_equal_end_sectors;
        send_item(make_req(OP_INSERT, 8'd1, 48'd100, 16'd0, 1'b0));
        send_item(make_req(OP_INSERT, 8'd2, 48'd90, 16'd10, 1'b1));
        send_item(make_req(OP_INSERT, 8'd3, 48'd50, 16'd50, 1'b0));
        repeat (3)
            send_item(make_req(OP_DISPATCH, 8'd0, 48'd0, 16'd0, 1'b0));
    endtask

    // field extremes, including an end sector that needs the carry bit
    task automatic test_field_extremes;
        send_item(make_req(OP_INSERT, 8'hFF, START_MAX, COUNT_MAX, 1'b1));
        send_item(make_req(OP_INSERT, 8'h00, '0, '0, 1'b0));
        send_item(make_req(OP_INSERT, 8'h80, START_MAX, '0, 1'b1));
        send_item(make_req(OP_INSERT, 8'h7F, '0, COUNT_MAX, 1'b0));
    endtask

    // fill to capacity, then one insert that must be dropped
    task automatic test_full_queue;
        while (sorted_reqs.size() < QUEUE_DEPTH)
            send_item(random_request(100));
        send_item(random_request(100));
    endtask

    // random traffic in bursts that lean toward filling, balancing or draining
    task automatic test_random_traffic(input int idle_pct, input int stall_rate,
                                       input int n_items);
        int insert_pct;
        insert_pct = 50;
        send_idle_pct = idle_pct;
        stall_pct = stall_rate;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 20 == 0)
            begin
                case ($urandom_range(2))
                    0: insert_pct = 85;
                    1: insert_pct = 50;
                    default: insert_pct = 15;
                endcase
            end
            send_item(random_request(insert_pct));
        end
        wait_for_results;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_dispatch;
        test_equal_end_sectors;
        test_field_extremes;
        test_full_queue;
        test_random_traffic(0, 0, 175);
        test_random_traffic(72, 0, 175);
        test_random_traffic(0, 72, 175);
        test_random_traffic(14, 14, 175);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
